[rtl/affine_point_transform_unit_macros.svh]
// ----------------------------------------------------------------------------
// Affine point transform unit assertion macros
// Shared assertion wrappers; they assume a clock named clk and a reset rst.
// ----------------------------------------------------------------------------
`ifndef AFFINE_POINT_TRANSFORM_UNIT_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define APT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APT_ASSERT_SAME(lbl, ante, cons, msg)
`define APT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/apt_pkg.sv]
// ----------------------------------------------------------------------------
// Affine point transform package
// Widths, register map, reset values and payload types of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEFF_WIDTH = 16;
  localparam int COEFF_FRAC  = COEFF_WIDTH - 2;
  localparam int ROW_WIDTH   = 48;
  localparam int PROD_WIDTH  = COORD_WIDTH + COEFF_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 3;
  localparam int RND_WIDTH   = SUM_WIDTH - COEFF_FRAC;
  localparam int PDATA_WIDTH = 64;
  localparam int PADDR_WIDTH = 6;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_WIDTH = PADDR_WIDTH - REG_SEL_LSB;

  localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = ROW_WIDTH'(1) << COEFF_FRAC;
  localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = ROW_WIDTH'(1) << (COEFF_FRAC + COEFF_WIDTH);
  localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET =
    ROW_WIDTH'(1) << (COEFF_FRAC + 2 * COEFF_WIDTH);

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam logic FUNC_DIRECTION = 1'b1;

  typedef enum logic [REG_SEL_WIDTH-1:0] {
    REG_ROW_X    = 3'd0,
    REG_ROW_Y    = 3'd1,
    REG_ROW_Z    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                          func;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
  } req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          overflow;
  } rsp_t;

  typedef struct packed {
    logic        [ROW_WIDTH-1:0]   row_x;
    logic        [ROW_WIDTH-1:0]   row_y;
    logic        [ROW_WIDTH-1:0]   row_z;
    logic signed [COORD_WIDTH-1:0] offset_x;
    logic signed [COORD_WIDTH-1:0] offset_y;
    logic signed [COORD_WIDTH-1:0] offset_z;
  } cfg_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic point;
  } stage_ctrl_t;

endpackage

[rtl/apt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Affine point transform configuration registers
// APB register file holding the matrix rows and the translation column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_cfg_regs import apt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[PADDR_WIDTH-1:REG_SEL_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_x    <= ROW_X_RESET;
      cfg.row_y    <= ROW_Y_RESET;
      cfg.row_z    <= ROW_Z_RESET;
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.offset_z <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_ROW_X:    cfg.row_x    <= pwdata[ROW_WIDTH-1:0];
        REG_ROW_Y:    cfg.row_y    <= pwdata[ROW_WIDTH-1:0];
        REG_ROW_Z:    cfg.row_z    <= pwdata[ROW_WIDTH-1:0];
        REG_OFFSET_X: cfg.offset_x <= pwdata[COORD_WIDTH-1:0];
        REG_OFFSET_Y: cfg.offset_y <= pwdata[COORD_WIDTH-1:0];
        REG_OFFSET_Z: cfg.offset_z <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ROW_X:    prdata = PDATA_WIDTH'(cfg.row_x);
      REG_ROW_Y:    prdata = PDATA_WIDTH'(cfg.row_y);
      REG_ROW_Z:    prdata = PDATA_WIDTH'(cfg.row_z);
      REG_OFFSET_X: prdata = PDATA_WIDTH'(unsigned'(cfg.offset_x));
      REG_OFFSET_Y: prdata = PDATA_WIDTH'(unsigned'(cfg.offset_y));
      REG_OFFSET_Z: prdata = PDATA_WIDTH'(unsigned'(cfg.offset_z));
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/apt_row_pipe.sv]
// ----------------------------------------------------------------------------
// Affine point transform row pipeline
// Four-stage datapath for one output component: multiply, partial sums,
// final sum with rounding shift, and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_row_pipe import apt_pkg::*; (
  input  logic                          clk,
  input  stage_ctrl_t                   ctrl,
  input  logic        [ROW_WIDTH-1:0]   coeffs,
  input  logic signed [COORD_WIDTH-1:0] offset,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  output logic signed [COORD_WIDTH-1:0] value,
  output logic                          sat
);

  localparam logic signed [SUM_WIDTH-1:0] ROUND_BIAS = SUM_WIDTH'(1) << (COEFF_FRAC - 1);

  logic signed [COEFF_WIDTH-1:0] c0;
  logic signed [COEFF_WIDTH-1:0] c1;
  logic signed [COEFF_WIDTH-1:0] c2;
  logic signed [PROD_WIDTH-1:0]  p0;
  logic signed [PROD_WIDTH-1:0]  p1;
  logic signed [PROD_WIDTH-1:0]  p2;
  logic signed [SUM_WIDTH-1:0]   off_term;
  logic signed [SUM_WIDTH-1:0]   sum_a;
  logic signed [SUM_WIDTH-1:0]   sum_b;
  logic signed [SUM_WIDTH-1:0]   total;
  logic signed [RND_WIDTH-1:0]   rounded;
  logic                          fits;

  assign c0 = coeffs[0*COEFF_WIDTH +: COEFF_WIDTH];
  assign c1 = coeffs[1*COEFF_WIDTH +: COEFF_WIDTH];
  assign c2 = coeffs[2*COEFF_WIDTH +: COEFF_WIDTH];

  assign off_term = ctrl.point ? (SUM_WIDTH'(offset) <<< COEFF_FRAC) : '0;
  assign total    = sum_a + sum_b;
  assign fits     = (rounded[RND_WIDTH-1:COORD_WIDTH-1] == '0) ||
                    (rounded[RND_WIDTH-1:COORD_WIDTH-1] == '1);

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      p0 <= c0 * coord_x;
      p1 <= c1 * coord_y;
      p2 <= c2 * coord_z;
    end
    if (ctrl.en2) begin
      sum_a <= SUM_WIDTH'(p0) + SUM_WIDTH'(p1);
      sum_b <= SUM_WIDTH'(p2) + off_term + ROUND_BIAS;
    end
    if (ctrl.en3) begin
      rounded <= RND_WIDTH'(total >>> COEFF_FRAC);
    end
    if (ctrl.en4) begin
      sat <= !fits;
      if (fits) begin
        value <= rounded[COORD_WIDTH-1:0];
      end else begin
        value <= rounded[RND_WIDTH-1] ? COORD_MIN : COORD_MAX;
      end
    end
  end

endmodule

[rtl/affine_point_transform_unit.sv]
// ----------------------------------------------------------------------------
// Affine point transform unit
// Requests pass the pipeline stages in order: multiply, partial sums,
// rounding shift, saturation. Throughput is one request per cycle unless
// rsp_ready holds it back; each stage refills as soon as the next one moves on.
// Synchronous reset empties the pipeline and loads the identity transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "affine_point_transform_unit_macros.svh"

module affine_point_transform_unit import apt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req_data,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp_data
);

  cfg_t        cfg;
  stage_ctrl_t ctrl;
  logic        v1;
  logic        v2;
  logic        v3;
  logic        v4;
  logic        func1;
  logic        sat_x;
  logic        sat_y;
  logic        sat_z;

  apt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    ctrl.en4   = !v4 || rsp_ready;
    ctrl.en3   = !v3 || ctrl.en4;
    ctrl.en2   = !v2 || ctrl.en3;
    ctrl.en1   = !v1 || ctrl.en2;
    ctrl.point = (func1 != FUNC_DIRECTION);
  end

  assign req_ready = ctrl.en1;
  assign rsp_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ctrl.en1) begin
        v1 <= req_valid;
      end
      if (ctrl.en2) begin
        v2 <= v1;
      end
      if (ctrl.en3) begin
        v3 <= v2;
      end
      if (ctrl.en4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      func1 <= req_data.func;
    end
  end

  apt_row_pipe u_row_x (
    .clk     (clk),
    .ctrl    (ctrl),
    .coeffs  (cfg.row_x),
    .offset  (cfg.offset_x),
    .coord_x (req_data.in_x),
    .coord_y (req_data.in_y),
    .coord_z (req_data.in_z),
    .value   (rsp_data.out_x),
    .sat     (sat_x)
  );

  apt_row_pipe u_row_y (
    .clk     (clk),
    .ctrl    (ctrl),
    .coeffs  (cfg.row_y),
    .offset  (cfg.offset_y),
    .coord_x (req_data.in_x),
    .coord_y (req_data.in_y),
    .coord_z (req_data.in_z),
    .value   (rsp_data.out_y),
    .sat     (sat_y)
  );

  apt_row_pipe u_row_z (
    .clk     (clk),
    .ctrl    (ctrl),
    .coeffs  (cfg.row_z),
    .offset  (cfg.offset_z),
    .coord_x (req_data.in_x),
    .coord_y (req_data.in_y),
    .coord_z (req_data.in_z),
    .value   (rsp_data.out_z),
    .sat     (sat_z)
  );

  assign rsp_data.overflow = sat_x || sat_y || sat_z;

  `APT_ASSERT_SAME(a_stall_means_full, !req_ready, v1 && v2 && v3 && v4, "stall with a free stage")
  `APT_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, v1, "accepted request not in stage one")
  `APT_ASSERT_SAME(a_sat_x_clamped, rsp_valid && sat_x, (rsp_data.out_x == COORD_MAX) || (rsp_data.out_x == COORD_MIN), "saturated x not at a bound")
  `APT_ASSERT_SAME(a_sat_z_clamped, rsp_valid && sat_z, (rsp_data.out_z == COORD_MAX) || (rsp_data.out_z == COORD_MIN), "saturated z not at a bound")

endmodule

[tb/sv/affine_point_transform_unit_tb.sv]
// ----------------------------------------------------------------------------
// Affine point transform unit testbench
// Drives coordinate requests and APB register writes into the unit and checks
// every result, field by field, against a local transform predictor. Covers
// the reset identity, rounding and saturation corners, long output stalls and
// a random stream over several matrix settings with random idling on both
// sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_point_transform_unit_tb;
  import apt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic FUNC_POINT = ~FUNC_DIRECTION;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  logic [ROW_WIDTH-1:0] row_coeffs [3] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
  logic signed [COORD_WIDTH-1:0] row_offsets [3] = '{default: '0};

  rsp_t expected_points [$];
  int errors = 0;
  int unsigned cycle_count = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  affine_point_transform_unit dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[affine_point_transform_unit] ERROR");
      $finish;
    end
  end

  function automatic rsp_t transform_point(input req_t item);
    rsp_t res;
    logic signed [63:0] coord [3];
    logic signed [63:0] acc;
    logic signed [63:0] term;
    logic signed [COORD_WIDTH-1:0] comp [3];
    res.overflow = 1'b0;
    coord[0] = 64'(item.in_x);
    coord[1] = 64'(item.in_y);
    coord[2] = 64'(item.in_z);
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        term = 64'($signed(row_coeffs[r][k*COEFF_WIDTH +: COEFF_WIDTH]));
        acc += term * coord[k];
      end
      if (item.func != FUNC_DIRECTION) begin
        term = 64'(row_offsets[r]);
        acc += term <<< COEFF_FRAC;
      end
      acc += 64'sd1 <<< (COEFF_FRAC - 1);
      acc = acc >>> COEFF_FRAC;
      if (acc > 64'(COORD_MAX)) begin
        comp[r] = COORD_MAX;
        res.overflow = 1'b1;
      end else if (acc < 64'(COORD_MIN)) begin
        comp[r] = COORD_MIN;
        res.overflow = 1'b1;
      end else begin
        comp[r] = acc[COORD_WIDTH-1:0];
      end
    end
    res.out_x = comp[0];
    res.out_y = comp[1];
    res.out_z = comp[2];
    return res;
  endfunction

  function automatic int idle_gap(input bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
    if (sel < 4) return $urandom;
    return $signed($urandom) >>> $urandom_range(4, 24);
  endfunction

  function automatic logic [COEFF_WIDTH-1:0] pick_coeff(input bit extreme);
    int sel;
    sel = extreme ? $urandom_range(0, 2) : $urandom_range(0, 6);
    case (sel)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  // Results are consumed with random stalls; a long hold can be requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      stall_left = idle_gap(recv_idle);
      rsp_ready <= (stall_left == 0);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_result
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, rsp_data);
        errors++;
      end else begin
        want = expected_points.pop_front();
        compare_field("out_x", want.out_x, rsp_data.out_x);
        compare_field("out_y", want.out_y, rsp_data.out_y);
        compare_field("out_z", want.out_z, rsp_data.out_z);
        compare_field("overflow", 32'(want.overflow), 32'(rsp_data.overflow));
      end
    end
  end

  task automatic send_request(input req_t item);
    int gap;
    gap = idle_gap(send_idle);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    do @(posedge clk); while (!req_ready);
    expected_points.push_back(transform_point(item));
  endtask

  task automatic send_coords(input logic func, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
    req_t item;
    item.func = func;
    item.in_x = x;
    item.in_y = y;
    item.in_z = z;
    send_request(item);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_coords(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, {REG_SEL_LSB{1'b0}}};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROW_X: row_coeffs[0] = value[ROW_WIDTH-1:0];
      REG_ROW_Y: row_coeffs[1] = value[ROW_WIDTH-1:0];
      REG_ROW_Z: row_coeffs[2] = value[ROW_WIDTH-1:0];
      REG_OFFSET_X: row_offsets[0] = value[COORD_WIDTH-1:0];
      REG_OFFSET_Y: row_offsets[1] = value[COORD_WIDTH-1:0];
      REG_OFFSET_Z: row_offsets[2] = value[COORD_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic write_row(input reg_idx_t idx, input logic [COEFF_WIDTH-1:0] c0,
                           input logic [COEFF_WIDTH-1:0] c1, input logic [COEFF_WIDTH-1:0] c2);
    write_reg(idx, {16'($urandom), c2, c1, c0});
  endtask

  task automatic write_offset(input reg_idx_t idx, input logic signed [31:0] offset);
    write_reg(idx, {$urandom, offset});
  endtask

  task automatic load_random_config(input bit extreme);
    write_row(REG_ROW_X, pick_coeff(extreme), pick_coeff(extreme), pick_coeff(extreme));
    write_row(REG_ROW_Y, pick_coeff(extreme), pick_coeff(extreme), pick_coeff(extreme));
    write_row(REG_ROW_Z, pick_coeff(extreme), pick_coeff(extreme), pick_coeff(extreme));
    if (extreme) begin
      write_offset(REG_OFFSET_X, ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN);
      write_offset(REG_OFFSET_Y, ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN);
      write_offset(REG_OFFSET_Z, ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN);
    end else begin
      write_offset(REG_OFFSET_X, pick_coord());
      write_offset(REG_OFFSET_Y, pick_coord());
      write_offset(REG_OFFSET_Z, pick_coord());
    end
  endtask

  task automatic test_reset_identity();
    send_coords(FUNC_POINT, 0, 0, 0);
    send_coords(FUNC_POINT, COORD_MAX, COORD_MIN, -1);
    send_coords(FUNC_DIRECTION, COORD_MIN, COORD_MAX, 1);
    send_coords(FUNC_POINT, 32'sh0001_0000, -32'sh0000_8000, 32'sh7FFF_0000);
    send_coords(FUNC_DIRECTION, -1, 0, COORD_MAX);
  endtask

  // The x row is the smallest coefficient alone, which exposes the rounding of
  // exact halves. The y row is -2.0 throughout, the z row nearly +2.0 but for
  // its centre; x, y offsets at range ends make sums land on and past both bounds.
  task automatic test_rounding_and_saturation();
    wait_drained();
    write_row(REG_ROW_X, 16'h0001, 16'h0000, 16'h0000);
    write_row(REG_ROW_Y, 16'h8000, 16'h8000, 16'h8000);
    write_row(REG_ROW_Z, 16'h7FFF, 16'h0000, 16'h7FFF);
    write_offset(REG_OFFSET_X, COORD_MAX);
    write_offset(REG_OFFSET_Y, COORD_MIN);
    write_offset(REG_OFFSET_Z, -1);
    send_coords(FUNC_DIRECTION, 8192, 0, 0);
    send_coords(FUNC_DIRECTION, -8192, 0, 0);
    send_coords(FUNC_DIRECTION, 8191, 0, 0);
    send_coords(FUNC_DIRECTION, -8193, 0, 0);
    send_coords(FUNC_DIRECTION, COORD_MIN, COORD_MIN, COORD_MIN);
    send_coords(FUNC_DIRECTION, COORD_MAX, COORD_MAX, COORD_MAX);
    send_coords(FUNC_POINT, 0, 0, 0);
    send_coords(FUNC_POINT, 1, 0, 0);
    send_coords(FUNC_POINT, 8192, 0, 0);
    send_coords(FUNC_DIRECTION, COORD_MIN, 0, COORD_MAX);
    send_coords(FUNC_POINT, COORD_MAX, COORD_MIN, COORD_MAX);
  endtask

  task automatic test_receiver_backpressure();
    wait_drained();
    load_random_config(1'b0);
    send_idle = 1'b0;
    hold_left = 250;
    send_random(80);
    send_idle = 1'b1;
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      load_random_config(phase == 1 || phase == 4);
      for (int chunk = 0; chunk < 6; chunk++) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        if (chunk == 3) wait_drained();
        send_random(50);
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_identity();
    test_rounding_and_saturation();
    test_receiver_backpressure();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[affine_point_transform_unit] OK");
    end else begin
      $display("[affine_point_transform_unit] ERROR");
    end
    $finish;
  end

endmodule
